/* rtl/mrt_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and helpers for the macro reference tokenizer
// no dependencies

package mrt_pkg;

   localparam int MaxResults = 3;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_PAREN_OPEN = 8'h28;
   localparam logic [7:0] CHAR_PAREN_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_BRACE_OPEN = 8'h7B;
   localparam logic [7:0] CHAR_BRACE_CLOSE = 8'h7D;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   localparam logic TOK_LITERAL = 1'b0;
   localparam logic TOK_NAME = 1'b1;

   typedef enum logic [1:0] {
      ITEM_BYTE = 2'd0,
      ITEM_END = 2'd1,
      ITEM_INCOMPLETE = 2'd2,
      ITEM_EMPTY = 2'd3
   } item_kind_type;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_DOLLAR = 2'd1,
      MODE_BRACKET = 2'd2,
      MODE_PLAIN = 2'd3
   } mode_type;

   typedef struct packed {
      item_kind_type item_kind;
      logic token_kind;
      logic [7:0] char_out;
   } result_type;

   // all results caused by one input byte
   typedef struct packed {
      logic [1:0] count;
      result_type [MaxResults-1:0] res;
   } bundle_type;

   function automatic logic is_name_byte(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || (c == CHAR_UNDERSCORE);
   endfunction

   function automatic bundle_type add_result(bundle_type b, item_kind_type kind,
                                             logic tok, logic [7:0] ch);
      bundle_type r;
      r = b;
      if (b.count < 2'(MaxResults)) begin
         r.res[b.count].item_kind = kind;
         r.res[b.count].token_kind = tok;
         r.res[b.count].char_out = ch;
         r.count = b.count + 2'd1;
      end
      return r;
   endfunction

endpackage

/* rtl/mrt_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for input bytes and result items
// no dependencies

interface mrt_req_if;
   logic valid;
   logic ready;
   logic [7:0] char_in;
   logic end_of_string;

   modport source (output valid, output char_in, output end_of_string, input ready);
   modport sink (input valid, input char_in, input end_of_string, output ready);
endinterface

interface mrt_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] item_kind;
   logic token_kind;
   logic [7:0] char_out;
   logic last_result;

   modport source (output valid, output item_kind, output token_kind,
                   output char_out, output last_result, input ready);
   modport sink (input valid, input item_kind, input token_kind,
                 input char_out, input last_result, output ready);
endinterface

/* rtl/macro_reference_tokenizer_unit.sv */
`timescale 1ns / 1ps
// top level of the macro reference tokenizer: front, queue, back
// depends on mrt_pkg, mrt_if, mrt_front, mrt_queue, mrt_back
//
//   channel   dir   payload                                       handshake
//   req_ch    in    char_in, end_of_string                         valid/ready
//   rsp_ch    out   item_kind, token_kind, char_out, last_result   valid/ready
//
// one byte accepted per cycle while ready is high; its zero to three results leave
// one word per cycle while rsp_ch.ready is high; the back end sends them in order
// the two-entry queue takes bytes while the output is stalled, ready drops when full
// first result passes the queue, then the back end register, before it appears
// synchronous reset returns the parser to text mode and empties the queue

module macro_reference_tokenizer_unit
   import mrt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mrt_req_if.sink req_ch,
   mrt_rsp_if.source rsp_ch
);

   logic q_push;
   logic q_full;
   logic q_pop;
   logic q_not_empty;
   bundle_type push_data;
   bundle_type pop_data;

   mrt_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (push_data)
   );

   mrt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (pop_data)
   );

   mrt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (pop_data),
      .q_pop       (q_pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

/* rtl/mrt_front.sv */
`timescale 1ns / 1ps
// front end: parse state machine, turns each byte into a bundle of results
// depends on mrt_pkg and mrt_if

module mrt_front
   import mrt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mrt_req_if.sink req_ch,
   input  logic q_full,
   output logic q_push,
   output bundle_type q_data
);

   mode_type mode_ff, mode_in;
   logic brace_ff, brace_in;
   logic lit_ff, lit_in;
   logic nonempty_ff, nonempty_in;
   logic err_ff, err_in;
   logic accept;

   assign req_ch.ready = !q_full;
   assign accept = req_ch.valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         brace_ff <= 1'b0;
         lit_ff <= 1'b0;
         nonempty_ff <= 1'b0;
         err_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         brace_ff <= brace_in;
         lit_ff <= lit_in;
         nonempty_ff <= nonempty_in;
         err_ff <= err_in;
      end
   end

   always_comb begin
      logic [7:0] c;
      logic eos;
      logic do_text;
      bundle_type b;
      c = req_ch.char_in;
      eos = req_ch.end_of_string;
      do_text = 1'b0;
      b = '0;
      mode_in = mode_ff;
      brace_in = brace_ff;
      lit_in = lit_ff;
      nonempty_in = nonempty_ff;
      err_in = err_ff;

      if (err_ff) begin
         if (eos) begin
            mode_in = MODE_TEXT;
            brace_in = 1'b0;
            lit_in = 1'b0;
            nonempty_in = 1'b0;
            err_in = 1'b0;
         end
      end else begin
         case (mode_ff)
            MODE_DOLLAR: begin
               if (c == CHAR_DOLLAR) begin
                  b = add_result(b, ITEM_BYTE, TOK_LITERAL, c);
                  lit_in = 1'b1;
                  mode_in = MODE_TEXT;
               end else begin
                  if (lit_ff) begin
                     b = add_result(b, ITEM_END, TOK_LITERAL, 8'd0);
                     lit_in = 1'b0;
                  end
                  if (c == CHAR_PAREN_OPEN || c == CHAR_BRACE_OPEN) begin
                     mode_in = MODE_BRACKET;
                     brace_in = (c == CHAR_BRACE_OPEN);
                     nonempty_in = 1'b0;
                  end else if (is_name_byte(c)) begin
                     b = add_result(b, ITEM_BYTE, TOK_NAME, c);
                     mode_in = MODE_PLAIN;
                  end else begin
                     b = add_result(b, ITEM_EMPTY, TOK_LITERAL, 8'd0);
                     mode_in = MODE_TEXT;
                     brace_in = 1'b0;
                     lit_in = 1'b0;
                     nonempty_in = 1'b0;
                     err_in = 1'b1;
                  end
               end
            end
            MODE_BRACKET: begin
               if (c == (brace_ff ? CHAR_BRACE_CLOSE : CHAR_PAREN_CLOSE)) begin
                  if (nonempty_ff) begin
                     b = add_result(b, ITEM_END, TOK_NAME, 8'd0);
                     mode_in = MODE_TEXT;
                     nonempty_in = 1'b0;
                     brace_in = 1'b0;
                  end else begin
                     b = add_result(b, ITEM_EMPTY, TOK_LITERAL, 8'd0);
                     mode_in = MODE_TEXT;
                     brace_in = 1'b0;
                     lit_in = 1'b0;
                     nonempty_in = 1'b0;
                     err_in = 1'b1;
                  end
               end else begin
                  b = add_result(b, ITEM_BYTE, TOK_NAME, c);
                  nonempty_in = 1'b1;
               end
            end
            MODE_PLAIN: begin
               if (is_name_byte(c)) begin
                  b = add_result(b, ITEM_BYTE, TOK_NAME, c);
               end else begin
                  b = add_result(b, ITEM_END, TOK_NAME, 8'd0);
                  mode_in = MODE_TEXT;
                  do_text = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_TEXT;
               do_text = 1'b1;
            end
         endcase

         // text-mode byte, or the byte ending a plain name, handled as ordinary text
         if (do_text) begin
            if (c == CHAR_DOLLAR) begin
               mode_in = MODE_DOLLAR;
            end else begin
               b = add_result(b, ITEM_BYTE, TOK_LITERAL, c);
               lit_in = 1'b1;
            end
         end

         if (eos) begin
            if (!err_in) begin
               case (mode_in)
                  MODE_DOLLAR: begin
                     if (lit_in) begin
                        b = add_result(b, ITEM_END, TOK_LITERAL, 8'd0);
                     end
                     b = add_result(b, ITEM_EMPTY, TOK_LITERAL, 8'd0);
                  end
                  MODE_BRACKET: begin
                     b = add_result(b, ITEM_INCOMPLETE, TOK_LITERAL, 8'd0);
                  end
                  MODE_PLAIN: begin
                     b = add_result(b, ITEM_END, TOK_NAME, 8'd0);
                  end
                  default: begin
                     if (lit_in) begin
                        b = add_result(b, ITEM_END, TOK_LITERAL, 8'd0);
                     end
                  end
               endcase
            end
            mode_in = MODE_TEXT;
            brace_in = 1'b0;
            lit_in = 1'b0;
            nonempty_in = 1'b0;
            err_in = 1'b0;
         end
      end

      q_data = b;
      q_push = accept && (b.count != 2'd0);
   end

endmodule

/* rtl/mrt_queue.sv */
`timescale 1ns / 1ps
// two-entry bundle queue between front and back
// depends on mrt_pkg

module mrt_queue
   import mrt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  bundle_type push_data,
   output logic full,
   input  logic pop,
   output logic not_empty,
   output bundle_type pop_data
);

   bundle_type [1:0] entry_ff;
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_pop;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_pop = pop && not_empty;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/mrt_back.sv */
`timescale 1ns / 1ps
// back end: holds one bundle, sends a result word per cycle if ready
// depends on mrt_pkg and mrt_if

module mrt_back
   import mrt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic q_not_empty,
   input  bundle_type q_data,
   output logic q_pop,
   mrt_rsp_if.source rsp_ch
);

   logic cur_valid_ff, cur_valid_in;
   bundle_type cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic is_last;
   logic sent;
   logic load;

   assign is_last = (idx_ff == cur_ff.count - 2'd1);
   assign sent = cur_valid_ff && rsp_ch.ready;
   assign load = !cur_valid_ff || (sent && is_last);
   assign q_pop = load && q_not_empty;

   always_comb begin
      cur_valid_in = load ? q_not_empty : cur_valid_ff;
      cur_in = q_pop ? q_data : cur_ff;
      if (load) begin
         idx_in = 2'd0;
      end else if (sent) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_ch.valid = cur_valid_ff;
   assign rsp_ch.item_kind = cur_ff.res[idx_ff].item_kind;
   assign rsp_ch.token_kind = cur_ff.res[idx_ff].token_kind;
   assign rsp_ch.char_out = cur_ff.res[idx_ff].char_out;
   assign rsp_ch.last_result = is_last;

endmodule
